// ===== design/lfu_pkg.sv =====
package lfu_pkg;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned STP_W = 64;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

  typedef struct packed {
    logic                    is_put;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } rsp_t;

endpackage

// ===== design/lfu_if.sv =====
interface lfu_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] key;
  logic signed [31:0] value;
  modport source (output valid, op, key, value, input ready);
  modport sink (input valid, op, key, value, output ready);
endinterface

interface lfu_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;
  logic               evicted;
  logic signed [31:0] evicted_key;
  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/lfu_cache_table_top.sv =====
// The back end takes one request from the queue at a time, only in S_IDLE, and
// scans the entry memories one entry at a time (registered read in S_RD, then
// compare in S_CMP), then registers the result in S_EXEC, stalling while the last result is untaken.
// A two-entry request queue decouples the input from the scan.
// Reset (rst_n, synchronous, active low) empties the table and queue and sets capacity to 16.
module lfu_cache_table_top import lfu_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lfu_req_if.sink   in_ch,
  lfu_rsp_if.source out_ch,
  lfu_cfg_if.sink   cfg_ch
);

  logic q_valid, q_ready;
  req_t q_req;

  lfu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req)
  );

  lfu_back #(.ENTRIES(ENTRIES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_req   (q_req),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_push_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> q_valid)
    else $error("accepted request not queued");

  a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !q_ready |=> q_valid && $stable(q_req))
    else $error("queue head changed while stalled");
`endif

endmodule

// ===== design/lfu_front.sv =====
module lfu_front import lfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lfu_req_if.sink     in_ch,
  output logic        q_valid,
  input  logic        q_ready,
  output req_t        q_req
);

  req_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  req_t       req;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && q_ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_req       = buf_r[rp_r];

  always_comb begin
    req.is_put = (in_ch.op == OP_PUT);
    req.key    = in_ch.key;
    req.value  = in_ch.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= req;
  end

endmodule

// ===== design/lfu_back.sv =====
module lfu_back import lfu_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_ready,
  input  req_t    q_req,
  lfu_cfg_if.sink cfg_ch,
  lfu_rsp_if.source out_ch
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > CAP_W) ? OW : CAP_W;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_CMP, S_EXEC} state_t;

  state_t             state_r;
  logic [CAP_W-1:0]   cap_r;
  logic [ENTRIES-1:0] valid_r;
  logic [OW-1:0]      occ_r;
  logic [STP_W-1:0]   tc_r;
  logic [IW-1:0]      idx_r;
  req_t               req_r;

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];
  logic [CNT_W-1:0] cnt_mem [ENTRIES];
  logic [STP_W-1:0] stp_mem [ENTRIES];

  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic [STP_W-1:0] rd_stp_r;

  logic             found_r, vic_any_r, free_any_r;
  logic [IW-1:0]    fidx_r, vidx_r, free_r;
  logic [VAL_W-1:0] fval_r;
  logic [CNT_W-1:0] fcnt_r, vcnt_r;
  logic [STP_W-1:0] vstp_r;
  logic [KEY_W-1:0] vkey_r;

  logic             out_valid_r;
  rsp_t             out_r;

  // execute-stage decode
  logic [CW-1:0]      cap_ext, cap_eff;
  logic               can_exec, do_evict, do_ins, slot_ok, we;
  logic [IW-1:0]      slot, waddr;
  logic [VAL_W-1:0]   wval;
  logic [CNT_W-1:0]   wcnt;
  logic               cur_v, better;
  logic [ENTRIES-1:0] valid_nxt;

  assign cfg_ch.ready = 1'b1;
  assign q_ready      = (state_r == S_IDLE);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_r.hit;
  assign out_ch.read_value  = out_r.read_value;
  assign out_ch.evicted     = out_r.evicted;
  assign out_ch.evicted_key = out_r.evicted_key;

  assign cur_v  = valid_r[idx_r];
  assign better = !vic_any_r || (rd_cnt_r < vcnt_r) ||
                  ((rd_cnt_r == vcnt_r) && (rd_stp_r < vstp_r));

  always_comb begin
    cap_ext  = CW'(cap_r);
    cap_eff  = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
    can_exec = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
    do_ins   = !found_r && req_r.is_put && (cap_eff != '0);
    do_evict = do_ins && (CW'(occ_r) >= cap_eff) && vic_any_r;
    slot_ok  = 1'b1;
    slot     = free_r;
    if (do_evict && (!free_any_r || vidx_r < free_r)) begin
      slot = vidx_r;
    end else if (!free_any_r) begin
      slot_ok = 1'b0;
    end
    we    = can_exec && (found_r || (do_ins && slot_ok));
    waddr = found_r ? fidx_r : slot;
    wval  = (found_r && !req_r.is_put) ? fval_r : req_r.value;
    wcnt  = !found_r ? CNT_W'(1) : ((fcnt_r == CNT_MAX) ? fcnt_r : fcnt_r + 1'b1);
    valid_nxt = valid_r;
    if (do_evict) valid_nxt[vidx_r] = 1'b0;
    if (do_ins && slot_ok) valid_nxt[slot] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      rd_key_r <= key_mem[idx_r];
      rd_val_r <= val_mem[idx_r];
      rd_cnt_r <= cnt_mem[idx_r];
      rd_stp_r <= stp_mem[idx_r];
    end
    if (we) begin
      key_mem[waddr] <= req_r.key;
      val_mem[waddr] <= wval;
      cnt_mem[waddr] <= wcnt;
      stp_mem[waddr] <= tc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      occ_r       <= '0;
      tc_r        <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      vic_any_r   <= 1'b0;
      free_any_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) cap_r <= cfg_ch.data;
      if (can_exec) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            req_r      <= q_req;
            idx_r      <= '0;
            found_r    <= 1'b0;
            vic_any_r  <= 1'b0;
            free_any_r <= 1'b0;
            state_r    <= S_RD;
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (cur_v && !found_r && (rd_key_r == req_r.key)) begin
            found_r <= 1'b1;
            fidx_r  <= idx_r;
            fval_r  <= rd_val_r;
            fcnt_r  <= rd_cnt_r;
          end
          if (cur_v && better) begin
            vic_any_r <= 1'b1;
            vidx_r    <= idx_r;
            vcnt_r    <= rd_cnt_r;
            vstp_r    <= rd_stp_r;
            vkey_r    <= rd_key_r;
          end
          if (!cur_v && !free_any_r) begin
            free_any_r <= 1'b1;
            free_r     <= idx_r;
          end
          if (idx_r == IW'(ENTRIES - 1)) begin
            state_r <= S_EXEC;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_EXEC: begin
          if (can_exec) begin
            out_r.hit          <= found_r;
            out_r.read_value   <= (found_r && !req_r.is_put) ? fval_r : MISS_VALUE;
            out_r.evicted      <= do_evict;
            out_r.evicted_key  <= do_evict ? vkey_r : '0;
            if (we) tc_r <= tc_r + 1'b1;
            valid_r <= valid_nxt;
            occ_r <= occ_r - OW'(do_evict) + OW'(!found_r && do_ins && slot_ok);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import lfu_pkg::*;

  localparam int NSLOT = 16;
  localparam int WDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;

  lfu_req_if in_ch();
  lfu_rsp_if out_ch();
  lfu_cfg_if cfg_ch();

  lfu_cache_table_top #(.ENTRIES(NSLOT)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // cache shadow
  logic [4:0]  sh_cap;
  logic        sh_valid [NSLOT];
  logic [31:0] sh_key [NSLOT];
  logic [31:0] sh_val [NSLOT];
  logic [31:0] sh_cnt [NSLOT];
  logic [63:0] sh_stamp [NSLOT];
  logic [63:0] sh_touch;
  int          sh_occ;

  rsp_t        pending_rsp[$];
  int          mismatches;
  int          wdog;
  logic [31:0] keys_seen[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void shadow_reset();
    sh_cap = CAP_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 1'b0;
    end
    sh_touch = '0;
    sh_occ = 0;
  endfunction

  function automatic rsp_t cache_access(logic op, logic [31:0] k, logic [31:0] v);
    rsp_t r;
    int found;
    int victim;
    int slot;
    int ecap;
    found = -1;
    victim = -1;
    slot = -1;
    ecap = (sh_cap > NSLOT) ? NSLOT : sh_cap;
    r.hit = 1'b0;
    r.read_value = MISS_VALUE;
    r.evicted = 1'b0;
    r.evicted_key = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (found < 0 && sh_valid[i] && sh_key[i] == k) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (op == OP_GET) r.read_value = sh_val[found];
      else sh_val[found] = v;
      if (sh_cnt[found] != CNT_MAX) sh_cnt[found]++;
      sh_stamp[found] = sh_touch;
      sh_touch++;
    end else if (op == OP_PUT && ecap > 0) begin
      if (sh_occ >= ecap) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (sh_valid[i] && (victim < 0 || sh_cnt[i] < sh_cnt[victim] ||
              (sh_cnt[i] == sh_cnt[victim] && sh_stamp[i] < sh_stamp[victim])))
            victim = i;
        end
        if (victim >= 0) begin
          sh_valid[victim] = 1'b0;
          if (sh_occ > 0) sh_occ--;
          r.evicted = 1'b1;
          r.evicted_key = sh_key[victim];
        end
      end
      for (int i = 0; i < NSLOT; i++) begin
        if (slot < 0 && !sh_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        sh_valid[slot] = 1'b1;
        sh_key[slot] = k;
        sh_val[slot] = v;
        sh_cnt[slot] = 1;
        sh_stamp[slot] = sh_touch;
        sh_touch++;
        sh_occ++;
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_request(logic op, logic [31:0] k, logic [31:0] v, bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.key <= k;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_rsp.push_back(cache_access(op, k, v));
    keys_seen.push_back(k);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (2 * NSLOT + 8) @(negedge clk);
  endtask

  task automatic write_capacity(logic [4:0] c);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sh_cap = c;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.hit = out_ch.hit;
      got.read_value = out_ch.read_value;
      got.evicted = out_ch.evicted;
      got.evicted_key = out_ch.evicted_key;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_rsp.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // sink stalls
  initial begin
    int g;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      g = gap_len();
      if (g != 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key(int span);
    if (keys_seen.size() != 0 && $urandom_range(99) < 70)
      return keys_seen[$urandom_range(keys_seen.size() - 1)];
    if ($urandom_range(9) == 0) return $urandom();
    return $urandom_range(span - 1);
  endfunction

  task automatic test_directed();
    send_request(OP_GET, 32'h8000_0000, '0);
    send_request(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_PUT, 32'h0, 32'h0);
    send_request(OP_GET, 32'h8000_0000, 32'h1234);
    send_request(OP_GET, 32'h7fff_ffff, '0);
    send_request(OP_PUT, 32'h0, 32'h5555_aaaa);
    send_request(OP_GET, 32'h0, '0);
    send_request(OP_GET, 32'h5, '0);
    for (int i = 1; i <= 14; i++) send_request(OP_PUT, 32'h100 + i, i, 1);
  endtask

  task automatic test_small_capacity();
    write_capacity(5'd1);
    for (int i = 0; i < 6; i++) send_request(OP_PUT, 32'(i[1:0]), $urandom());
    send_request(OP_GET, 32'h1, '0);
    write_capacity(5'd0);
    send_request(OP_PUT, 32'h999, 32'h1);
    send_request(OP_GET, 32'h999, '0);
    send_request(OP_PUT, 32'h1, 32'h2);
    write_capacity(5'd31);
    for (int i = 0; i < 20; i++) send_request(OP_PUT, 32'h200 + i, i);
    write_capacity(5'd3);
    for (int i = 0; i < 6; i++) send_request(OP_PUT, 32'h300 + i, i);
  endtask

  task automatic test_random(int n, int span);
    for (int i = 0; i < n; i++) begin
      send_request($urandom_range(99) < 55 ? OP_PUT : OP_GET, pick_key(span), $urandom());
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    mismatches = 0;
    wdog = 0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_GET;
    in_ch.key = '0;
    in_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    shadow_reset();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_small_capacity();
    write_capacity(5'd16);
    test_random(200, 40);
    write_capacity(5'd6);
    test_random(150, 20);
    write_capacity(5'd2);
    test_random(80, 8);
    write_capacity(5'd16);
    keys_seen.delete();
    test_random(80, 1000);
    drain();
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
